### src/dynamic_graph_adjacency_engine_defines.svh
// assertion macros shared by the checker of the graph engine
// no dependencies; taken in by include where assertions are written
`ifndef DYNAMIC_GRAPH_ADJACENCY_ENGINE_DEFINES_SVH
`define DYNAMIC_GRAPH_ADJACENCY_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define DGAE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define DGAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/dgae_pkg.sv
// types and constants of the graph adjacency engine
// no dependencies; imported by every module of the block
package dgae_pkg;

   localparam int ID_W     = 5;
   localparam int ID_CNT_W = 6;
   localparam int ROW_W    = 32;
   localparam int OP_W     = 3;
   localparam int ST_W     = 2;
   localparam int DEG_W    = 6;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD_EDGE      = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE_EDGE   = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD_VERTEX    = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE_VERTEX = 3'd3;
   localparam logic [OP_W-1:0] OP_CONTRACT      = 3'd4;
   localparam logic [OP_W-1:0] OP_DEGREE        = 3'd5;
   localparam logic [OP_W-1:0] OP_ADJACENT      = 3'd6;
   localparam logic [OP_W-1:0] OP_NEIGHBOURS    = 3'd7;

   // status codes
   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

   // one access to the row memory
   typedef struct packed {
      logic             rd_en;
      logic [ID_W-1:0]  rd_addr;
      logic             wr_en;
      logic [ID_W-1:0]  wr_addr;
      logic [ROW_W-1:0] wr_data;
   } mem_req_type;

   // how a sweep rewrites each row
   typedef struct packed {
      logic             merge;
      logic [ID_W-1:0]  keep;
      logic [ID_W-1:0]  gone;
      logic [ROW_W-1:0] moved;
   } row_upd_type;

endpackage

### src/dynamic_graph_adjacency_engine.sv
// Command paths: errors and add vertex answer straight from idle; degree, adjacent and
// neighbours read one row; add/remove edge read and rewrite both rows; remove vertex sweeps
// all VCAP rows (VCAP = min(MAX_VERTICES,32)); contract reads both rows, picks a survivor,
// then sweeps. One command at a time; busy drops in the strobe cycle, so the next beat may
// follow at once. The row memory's single read port and the row-by-row sweep shape these paths.
// Synchronous reset empties the graph at once; a row is zeroed when its vertex is created.
module dynamic_graph_adjacency_engine import dgae_pkg::*; #(
   parameter int MAX_VERTICES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [OP_W-1:0]  req_operation,
   input  logic [ID_W-1:0]  req_first_vertex,
   input  logic [ID_W-1:0]  req_target_vertex,
   output logic             rsp_valid,
   output logic [ST_W-1:0]  rsp_status,
   output logic [ID_W-1:0]  rsp_vertex_id,
   output logic [DEG_W-1:0] rsp_degree,
   output logic             rsp_adjacent,
   output logic [ROW_W-1:0] rsp_neighbour_mask
);

   localparam int VCAP  = (MAX_VERTICES > 32) ? 32 : MAX_VERTICES;
   localparam int IDX_W = $clog2(VCAP);
   localparam int CNT_W = $clog2(VCAP + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD_A  = 3'd1;
   localparam logic [2:0] S_RD_B  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_SWEEP = 3'd4;

   function automatic logic is_present(input logic [ID_W-1:0] id,
                                       input logic [ROW_W-1:0] mask);
      return ({1'b0, id} < ID_CNT_W'(VCAP)) && mask[id];
   endfunction

   // popcount: eight-bit groups, then one small sum
   function automatic logic [DEG_W-1:0] popcount(input logic [ROW_W-1:0] x);
      logic [3:0] oct_cnt [4];
      for (int b = 0; b < 4; b++) begin
         oct_cnt[b] = '0;
         for (int k = 0; k < 8; k++) begin
            oct_cnt[b] = oct_cnt[b] + 4'(x[8*b+k]);
         end
      end
      return DEG_W'(oct_cnt[0]) + DEG_W'(oct_cnt[1]) + DEG_W'(oct_cnt[2])
             + DEG_W'(oct_cnt[3]);
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [ROW_W-1:0]    present_ff, present_in;
   logic [ID_CNT_W-1:0] next_id_ff, next_id_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [ID_W-1:0]     u_ff, u_in;
   logic [ID_W-1:0]     v_ff, v_in;
   logic [ROW_W-1:0]    row_a_ff, row_a_in;
   logic [ROW_W-1:0]    row_b_ff, row_b_in;
   row_upd_type         upd_ff, upd_in;
   logic [CNT_W-1:0]    rd_cnt_ff, rd_cnt_in;
   logic [ID_W-1:0]     wr_idx_ff, wr_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_vertex_id_ff, rsp_vertex_id_in;
   logic [DEG_W-1:0]    rsp_degree_ff, rsp_degree_in;
   logic                rsp_adjacent_ff, rsp_adjacent_in;
   logic [ROW_W-1:0]    rsp_neighbour_mask_ff, rsp_neighbour_mask_in;

   mem_req_type         mem_req;
   logic [ROW_W-1:0]    mem_rdata;
   logic [ROW_W-1:0]    sweep_row;
   logic                pu, pv;
   logic [DEG_W-1:0]    cnt_a, cnt_b;

   dgae_row_ram #(
      .DEPTH (VCAP)
   ) u_ram (
      .clock   (clock),
      .req     (mem_req),
      .rd_data (mem_rdata)
   );

   dgae_row_update u_upd (
      .upd     (upd_ff),
      .row_idx (wr_idx_ff),
      .row_in  (mem_rdata),
      .row_out (sweep_row)
   );

   assign pu    = is_present(req_first_vertex, present_ff);
   assign pv    = is_present(req_target_vertex, present_ff);
   assign cnt_a = popcount(row_a_ff);
   assign cnt_b = popcount(row_b_ff);

   // command sequencer; no two accesses of one command touch the same row
   // in overlapping cycles, so the memory needs no forwarding
   always_comb begin
      state_in              = state_ff;
      present_in            = present_ff;
      next_id_in            = next_id_ff;
      op_in                 = op_ff;
      u_in                  = u_ff;
      v_in                  = v_ff;
      row_a_in              = row_a_ff;
      row_b_in              = row_b_ff;
      upd_in                = upd_ff;
      rd_cnt_in             = rd_cnt_ff;
      wr_idx_in             = wr_idx_ff;
      rsp_valid_in          = 1'b0;
      rsp_status_in         = rsp_status_ff;
      rsp_vertex_id_in      = rsp_vertex_id_ff;
      rsp_degree_in         = rsp_degree_ff;
      rsp_adjacent_in       = rsp_adjacent_ff;
      rsp_neighbour_mask_in = rsp_neighbour_mask_ff;
      mem_req               = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_operation;
               u_in  = req_first_vertex;
               v_in  = req_target_vertex;
               // an immediate answer unless a longer path overrides it
               rsp_status_in         = ST_ABSENT;
               rsp_vertex_id_in      = '0;
               rsp_degree_in         = '0;
               rsp_adjacent_in       = 1'b0;
               rsp_neighbour_mask_in = '0;
               case (req_operation)
                  OP_ADD_EDGE, OP_REMOVE_EDGE, OP_CONTRACT: begin
                     if (pu && pv && (req_first_vertex != req_target_vertex)) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = req_first_vertex;
                        state_in        = S_RD_A;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_ADD_VERTEX: begin
                     rsp_valid_in = 1'b1;
                     if (next_id_ff >= ID_CNT_W'(VCAP)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = next_id_ff[ID_W-1:0];
                        mem_req.wr_data = '0;
                        present_in      = present_ff | (ROW_W'(1) << next_id_ff[ID_W-1:0]);
                        next_id_in      = next_id_ff + ID_CNT_W'(1);
                        rsp_status_in   = ST_OK;
                        rsp_vertex_id_in = next_id_ff[ID_W-1:0];
                     end
                  end
                  OP_REMOVE_VERTEX: begin
                     if (pv) begin
                        upd_in.merge = 1'b0;
                        upd_in.keep  = '0;
                        upd_in.gone  = req_target_vertex;
                        upd_in.moved = '0;
                        rd_cnt_in    = '0;
                        state_in     = S_SWEEP;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_DEGREE, OP_NEIGHBOURS: begin
                     if (pv) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = req_target_vertex;
                        state_in        = S_RD_B;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_ADJACENT: begin
                     if (pu && pv) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = req_first_vertex;
                        state_in        = S_RD_B;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // first row back; edge ops rewrite it, second row requested
         S_RD_A: begin
            row_a_in        = mem_rdata;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = v_ff;
            if (op_ff == OP_ADD_EDGE) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = u_ff;
               mem_req.wr_data = mem_rdata | (ROW_W'(1) << v_ff);
            end else if (op_ff == OP_REMOVE_EDGE) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = u_ff;
               mem_req.wr_data = mem_rdata & ~(ROW_W'(1) << v_ff);
            end
            state_in = S_RD_B;
         end

         // second row back (or the only row of a query)
         S_RD_B: begin
            rsp_status_in         = ST_OK;
            rsp_vertex_id_in      = '0;
            rsp_degree_in         = '0;
            rsp_adjacent_in       = 1'b0;
            rsp_neighbour_mask_in = '0;
            rsp_valid_in          = 1'b1;
            state_in              = S_IDLE;
            case (op_ff)
               OP_ADD_EDGE: begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = v_ff;
                  mem_req.wr_data = mem_rdata | (ROW_W'(1) << u_ff);
               end
               OP_REMOVE_EDGE: begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = v_ff;
                  mem_req.wr_data = mem_rdata & ~(ROW_W'(1) << u_ff);
               end
               OP_CONTRACT: begin
                  row_b_in     = mem_rdata;
                  rsp_valid_in = 1'b0;
                  state_in     = S_EVAL;
               end
               OP_DEGREE: begin
                  rsp_degree_in = popcount(mem_rdata);
               end
               OP_ADJACENT: begin
                  rsp_adjacent_in = (u_ff != v_ff) && mem_rdata[v_ff];
               end
               OP_NEIGHBOURS: begin
                  rsp_neighbour_mask_in = mem_rdata;
               end
               default: begin
                  rsp_status_in = ST_OK;
               end
            endcase
         end

         // pick survivor: fewer neighbours goes, a tie keeps the first vertex
         S_EVAL: begin
            upd_in.merge = 1'b1;
            if (cnt_a < cnt_b) begin
               upd_in.keep  = v_ff;
               upd_in.gone  = u_ff;
               upd_in.moved = row_a_ff & ~(ROW_W'(1) << v_ff) & ~(ROW_W'(1) << u_ff);
            end else begin
               upd_in.keep  = u_ff;
               upd_in.gone  = v_ff;
               upd_in.moved = row_b_ff & ~(ROW_W'(1) << u_ff) & ~(ROW_W'(1) << v_ff);
            end
            rd_cnt_in = '0;
            state_in  = S_SWEEP;
         end

         // read row i while row i-1 is written back
         S_SWEEP: begin
            if (rd_cnt_ff != CNT_W'(VCAP)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ID_W'(rd_cnt_ff[IDX_W-1:0]);
               wr_idx_in       = ID_W'(rd_cnt_ff[IDX_W-1:0]);
               rd_cnt_in       = rd_cnt_ff + CNT_W'(1);
            end
            if (rd_cnt_ff != '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = wr_idx_ff;
               mem_req.wr_data = sweep_row;
            end
            if (rd_cnt_ff == CNT_W'(VCAP)) begin
               present_in            = present_ff & ~(ROW_W'(1) << upd_ff.gone);
               rsp_valid_in          = 1'b1;
               rsp_status_in         = ST_OK;
               rsp_vertex_id_in      = upd_ff.merge ? upd_ff.keep : '0;
               rsp_degree_in         = '0;
               rsp_adjacent_in       = 1'b0;
               rsp_neighbour_mask_in = '0;
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         present_ff   <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      op_ff                 <= op_in;
      u_ff                  <= u_in;
      v_ff                  <= v_in;
      row_a_ff              <= row_a_in;
      row_b_ff              <= row_b_in;
      upd_ff                <= upd_in;
      rd_cnt_ff             <= rd_cnt_in;
      wr_idx_ff             <= wr_idx_in;
      rsp_status_ff         <= rsp_status_in;
      rsp_vertex_id_ff      <= rsp_vertex_id_in;
      rsp_degree_ff         <= rsp_degree_in;
      rsp_adjacent_ff       <= rsp_adjacent_in;
      rsp_neighbour_mask_ff <= rsp_neighbour_mask_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_vertex_id      = rsp_vertex_id_ff;
   assign rsp_degree         = rsp_degree_ff;
   assign rsp_adjacent       = rsp_adjacent_ff;
   assign rsp_neighbour_mask = rsp_neighbour_mask_ff;

endmodule

### src/dgae_row_ram.sv
// adjacency row memory: one write port, one read port, registered read data
// depends on dgae_pkg for the request type
module dgae_row_ram import dgae_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic             clock,
   input  mem_req_type      req,
   output logic [ROW_W-1:0] rd_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic [ROW_W-1:0] mem [DEPTH];
   logic [ROW_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/dgae_row_update.sv
// new value of one row during a removal or contraction sweep
// depends on dgae_pkg for the update descriptor
module dgae_row_update import dgae_pkg::*; (
   input  row_upd_type      upd,
   input  logic [ID_W-1:0]  row_idx,
   input  logic [ROW_W-1:0] row_in,
   output logic [ROW_W-1:0] row_out
);

   always_comb begin
      // drop the removed vertex from this row, and its own row entirely
      row_out = row_in & ~(ROW_W'(1) << upd.gone);
      if (row_idx == upd.gone) begin
         row_out = '0;
      end
      // survivor takes the moved neighbours, and they take the survivor
      if (upd.merge) begin
         if (row_idx == upd.keep) begin
            row_out = row_out | upd.moved;
         end
         if (upd.moved[row_idx]) begin
            row_out = row_out | (ROW_W'(1) << upd.keep);
         end
      end
   end

endmodule

### src/dgae_checker.sv
// port-level checks of the graph engine, bound to the top level
// depends on dgae_pkg and the assertion macro header
`include "dynamic_graph_adjacency_engine_defines.svh"

module dgae_checker import dgae_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [OP_W-1:0]  req_operation,
   input logic             rsp_valid,
   input logic [ST_W-1:0]  rsp_status,
   input logic [ID_W-1:0]  rsp_vertex_id,
   input logic [DEG_W-1:0] rsp_degree,
   input logic             rsp_adjacent,
   input logic [ROW_W-1:0] rsp_neighbour_mask
);

   // an error beat carries nothing but its status
   `DGAE_ASSERT_NOW(a_err_zero, clock, reset,
      rsp_valid && (rsp_status != ST_OK),
      (rsp_vertex_id == '0) && (rsp_degree == '0) && !rsp_adjacent
         && (rsp_neighbour_mask == '0),
      "error result with nonzero payload")

   // add vertex answers in the next cycle and frees the command port
   `DGAE_ASSERT_NEXT(a_add_vertex, clock, reset,
      start && !busy && (req_operation == OP_ADD_VERTEX),
      rsp_valid && !busy && (rsp_degree == '0) && (rsp_neighbour_mask == '0),
      "add vertex not answered at once")

   // a finished long command always delivers its beat
   `DGAE_ASSERT_NOW(a_done_resp, clock, reset, $fell(busy) && !$past(reset), rsp_valid,
      "busy dropped without a result")

   // no beat without a command accepted or in progress
   `DGAE_ASSERT_NOW(a_no_spurious, clock, reset, rsp_valid, $past(busy) || $past(start),
      "result without a command")

endmodule

bind dynamic_graph_adjacency_engine dgae_checker u_dgae_checker (.*);
